FILE: rtl/core/stt_pkg.sv
// Package for the sparse triple table: types, sizes and codes.
package stt_pkg;
  localparam int CAPACITY_DEF    = 256;
  localparam int INDEX_BITS      = 10;
  localparam int VALUE_BITS      = 32;
  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = INDEX_BITS;
  localparam int COUNT_BITS      = 9;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLUMN_COUNT = 1'd1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_WRITE  = 2'd1,
    OP_REJECT = 2'd2
  } op_t;

  typedef struct packed {
    logic                         req_type;
    logic [INDEX_BITS-1:0]        row_index;
    logic [INDEX_BITS-1:0]        column_index;
    logic signed [VALUE_BITS-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [VALUE_BITS-1:0] read_value;
    logic [COUNT_BITS-1:0]        entries_used;
  } rsp_t;

  typedef struct packed {
    op_t                     op;
    logic [2*INDEX_BITS-1:0] key;
    logic [VALUE_BITS-1:0]   value;
  } cmd_t;
endpackage

FILE: rtl/core/stt_front.sv
// Front end: registers sizes, range-checks write requests and queues commands.
module stt_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  stt_pkg::req_t                    req,
  input  logic                             cfg_we,
  input  logic [stt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [stt_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                             cmd_pop,
  output logic                             cmd_valid,
  output stt_pkg::cmd_t                    cmd,
  output logic                             full
);
  localparam int INDEX_BITS = stt_pkg::INDEX_BITS;
  localparam int VALUE_BITS = stt_pkg::VALUE_BITS;

  logic [INDEX_BITS-1:0] row_count;
  logic [INDEX_BITS-1:0] column_count;
  stt_pkg::cmd_t         q [2];
  logic                  wp, rp;
  logic [1:0]            cnt;
  stt_pkg::cmd_t         incoming;
  logic                  push;
  logic [INDEX_BITS-1:0] r, c;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      column_count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == stt_pkg::REG_ROW_COUNT) row_count <= cfg_data[INDEX_BITS-1:0];
      else column_count <= cfg_data[INDEX_BITS-1:0];
    end
  end

  assign r = req.row_index[INDEX_BITS-1:0];
  assign c = req.column_index[INDEX_BITS-1:0];

  always_comb begin
    incoming.key = {r, c};
    incoming.value = req.entry_value[VALUE_BITS-1:0];
    if (req.req_type) incoming.op = stt_pkg::OP_LOOKUP;
    else if (r == '0 || c == '0 || r > row_count || c > column_count)
      incoming.op = stt_pkg::OP_REJECT;
    else incoming.op = stt_pkg::OP_WRITE;
  end

  assign full = (cnt == 2'd2);
  assign push = start && !full;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= incoming;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (cmd_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, cmd_pop};
    end
  end
endmodule

FILE: rtl/core/stt_back.sv
// Back end: chain of sorted cells with parallel compare and shift.
module stt_back #(
  parameter int CAPACITY   = stt_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  stt_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          done,
  output stt_pkg::rsp_t rsp
);
  localparam int INDEX_BITS = stt_pkg::INDEX_BITS;
  localparam int VALUE_BITS = stt_pkg::VALUE_BITS;
  localparam int KB = 2 * INDEX_BITS;
  localparam int NB = $clog2(CAPACITY + 1);

  logic [KB-1:0]         ckey [CAPACITY];
  logic [VALUE_BITS-1:0] cval [CAPACITY];
  logic [NB-1:0]         n;

  // stage 1: per-cell compare results, registered
  logic [CAPACITY-1:0]   le, eq;
  logic                  s1;
  stt_pkg::cmd_t         c1;
  logic [VALUE_BITS-1:0] hitval;

  logic [CAPACITY-1:0]   le_c, eq_c;

  assign cmd_pop = cmd_valid && !s1;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le_c[i] = (i < n) && (ckey[i] <= cmd.key[KB-1:0]);
      eq_c[i] = (i < n) && (ckey[i] == cmd.key[KB-1:0]);
    end
  end

  // keys are unique, so at most one cell matches: plain OR tree
  logic [VALUE_BITS-1:0] hv_c;
  always_comb begin
    hv_c = '0;
    for (int i = 0; i < CAPACITY; i++)
      hv_c = hv_c | (cval[i] & {VALUE_BITS{eq_c[i]}});
  end

  always_ff @(posedge clk) begin
    if (rst) s1 <= 1'b0;
    else s1 <= cmd_pop;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      le <= le_c;
      eq <= eq_c;
      c1 <= cmd;
      hitval <= hv_c;
    end
  end

  // stage 2: act
  logic hit, isdel, isins, isupd, isfull;
  assign hit    = |eq;
  assign isfull = (n >= NB'(CAPACITY));
  assign isdel  = (c1.op == stt_pkg::OP_WRITE) && hit && (c1.value[VALUE_BITS-1:0] == '0);
  assign isupd  = (c1.op == stt_pkg::OP_WRITE) && hit && (c1.value[VALUE_BITS-1:0] != '0);
  assign isins  = (c1.op == stt_pkg::OP_WRITE) && !hit && (c1.value[VALUE_BITS-1:0] != '0)
                  && !isfull;

  always_ff @(posedge clk) begin
    if (s1) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (isupd && eq[i]) cval[i] <= c1.value[VALUE_BITS-1:0];
        else if (isdel && (eq[i] || !le[i]) && i + 1 < CAPACITY) begin
          // matching cell and everything above it move down one
          ckey[i] <= ckey[(i + 1) % CAPACITY];
          cval[i] <= cval[(i + 1) % CAPACITY];
        end else if (isins && !le[i]) begin
          if (i == 0 || le[(i + CAPACITY - 1) % CAPACITY]) begin
            ckey[i] <= c1.key[KB-1:0];
            cval[i] <= c1.value[VALUE_BITS-1:0];
          end else begin
            ckey[i] <= ckey[(i + CAPACITY - 1) % CAPACITY];
            cval[i] <= cval[(i + CAPACITY - 1) % CAPACITY];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) n <= '0;
    else if (s1 && isdel) n <= n - NB'(1);
    else if (s1 && isins) n <= n + NB'(1);
  end

  logic [NB-1:0] n_after;
  always_comb begin
    n_after = n;
    if (isdel) n_after = n - NB'(1);
    else if (isins) n_after = n + NB'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= s1;
  end

  always_ff @(posedge clk) begin
    if (s1) begin
      rsp.status <= (c1.op == stt_pkg::OP_REJECT) ? stt_pkg::ST_RANGE :
                    (c1.op == stt_pkg::OP_WRITE && !hit && c1.value[VALUE_BITS-1:0] != '0
                     && isfull) ? stt_pkg::ST_FULL : stt_pkg::ST_OK;
      rsp.read_value <= (c1.op == stt_pkg::OP_LOOKUP && hit) ? hitval : '0;
      rsp.entries_used <= 9'(n_after);
    end
  end
endmodule

FILE: rtl/core/sparse_triple_table.sv
// Top level of the sparse triple table.
//  channel   | signals                        | handshake
//  request   | start, busy, req               | accepted when start && !busy
//  result    | done, rsp                      | one cycle strobe, no stall
//  config    | cfg_we, cfg_index, cfg_data    | written when cfg_we
// A request passes compare, then shift/update in the cell chain, which
// takes no new command during shift/update. With the chain idle, done
// follows the queue, compare and update stages. A two-entry queue decouples
// intake from the cell chain; busy is high while it holds two transactions.
// Synchronous reset empties the table and clears the sizes.
module sparse_triple_table #(
  parameter int CAPACITY   = stt_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  stt_pkg::req_t                     req,
  output logic                              done,
  output stt_pkg::rsp_t                     rsp,
  input  logic                              cfg_we,
  input  logic [stt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [stt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  logic          cmd_valid, cmd_pop;
  stt_pkg::cmd_t cmd;

  stt_front u_front (
    .clk, .rst, .start, .req, .cfg_we, .cfg_index, .cfg_data,
    .cmd_pop, .cmd_valid, .cmd, .full(busy)
  );

  stt_back #(.CAPACITY(CAPACITY)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_pop, .done, .rsp
  );
endmodule
